### rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Types, phase codes and the CRC-16 byte fold shared by the reply deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

    // parser phase codes, code seven is unused and acts like the end phase
    typedef enum logic [2:0] {
        PH_ADDR  = 3'd0,
        PH_FUNC  = 3'd1,
        PH_COUNT = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRCHI = 3'd4,
        PH_CRCLO = 3'd5,
        PH_END   = 3'd6
    } phase_t;

    // input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic REG_EXPECTED_ADDR = 1'b0;

    localparam logic [7:0]  EXPECTED_ADDR_RESET = 8'd1;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'hA001;

    // input beat
    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } mrd_in_t;

    // result beat
    typedef struct packed {
        logic [2:0]  phase;
        logic        busy_res;
        logic [7:0]  resp_addr;
        logic [7:0]  resp_func;
        logic [7:0]  byte_count;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [15:0] crc_calc;
        logic [15:0] crc_received;
        logic        frame_end;
    } mrd_out_t;

    // one byte through the reflected modbus crc
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### rtl/modbus_rtu_reply_deframer_core.sv
// ----------------------------------------------------------------------------
// modbus_rtu_reply_deframer_core
// Byte-wise Modbus RTU reply parser with streamed data and running CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one beat per received byte (operation 0)
//   or a release request (operation 1) that returns the parser to idle.
//   m_valid/m_ready/m_data carry exactly one result beat per input beat:
//   phase, busy flag, header fields, any data byte with its index, the
//   running CRC and the received CRC.
//   The APB port holds the expected slave address at byte address 0.
// Pipeline and throughput:
//   a beat is captured in the input register, is parsed by one byte-wide
//   CRC fold and phase step, and is registered into the result register
//   that drives m_data.
//   One beat per cycle is sustained while m_ready stays high; the CRC fold
//   of one byte sets the critical path.
// Reset:
//   synchronous active-low aresetn clears the phase to idle, the CRC to
//   0xFFFF, the header and received CRC fields to zero and the expected
//   address to one; both pipeline registers empty.
// Stalls:
//   while m_ready is low the result register holds and one more beat is
//   buffered in the input register, after which s_ready drops.
// ----------------------------------------------------------------------------
module modbus_rtu_reply_deframer_core (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  mrd_pkg::mrd_in_t  s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output mrd_pkg::mrd_out_t m_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import mrd_pkg::*;

    logic [7:0] expected_addr;

    mrd_apb_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .expected_addr (expected_addr)
    );

    // pipeline registers
    logic     in_valid_reg;
    mrd_in_t  in_item_reg;
    logic     out_valid_reg;
    mrd_out_t out_item_reg;
    logic     advance;

    // parser state
    phase_t      phase_reg,   phase_next;
    logic [7:0]  addr_reg,    addr_next;
    logic [7:0]  func_reg,    func_next;
    logic [7:0]  count_reg,   count_next;
    logic [7:0]  index_reg,   index_next;
    logic [15:0] crc_reg,     crc_next;
    logic [15:0] crc_rx_reg,  crc_rx_next;
    mrd_out_t    result;

    logic [15:0] crc_folded;
    logic [7:0]  index_inc;
    logic [7:0]  rx;

    // move the buffered beat into the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign rx         = in_item_reg.rx_byte;
    assign crc_folded = crc_fold((phase_reg == PH_ADDR) ? CRC_INIT : crc_reg, rx);
    assign index_inc  = index_reg + 8'd1;

    // phase step and field capture
    always_comb begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        func_next   = func_reg;
        count_next  = count_reg;
        index_next  = index_reg;
        crc_next    = crc_reg;
        crc_rx_next = crc_rx_reg;
        result      = '0;
        if (in_item_reg.operation == OP_RELEASE) begin
            phase_next = PH_ADDR;
        end else begin
            unique case (phase_reg)
                PH_ADDR: begin
                    index_next = 8'd0;
                    crc_next   = crc_folded;
                    addr_next  = rx;
                    if (rx != expected_addr) begin
                        phase_next       = PH_END;
                        result.frame_end = 1'b1;
                    end else begin
                        phase_next = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    crc_next   = crc_folded;
                    func_next  = rx;
                    phase_next = PH_COUNT;
                end
                PH_COUNT: begin
                    crc_next   = crc_folded;
                    count_next = rx;
                    phase_next = (rx == 8'd0) ? PH_CRCHI : PH_DATA;
                end
                PH_DATA: begin
                    crc_next          = crc_folded;
                    result.data_valid = 1'b1;
                    result.data_byte  = rx;
                    result.data_index = index_reg;
                    index_next        = index_inc;
                    if (index_inc >= count_reg) begin
                        phase_next = PH_CRCHI;
                    end
                end
                PH_CRCHI: begin
                    crc_rx_next = {rx, crc_rx_reg[7:0]};
                    phase_next  = PH_CRCLO;
                end
                PH_CRCLO: begin
                    crc_rx_next      = {crc_rx_reg[15:8], rx};
                    phase_next       = PH_END;
                    result.frame_end = 1'b1;
                end
                default: begin
                    // end phase: bytes are ignored
                end
            endcase
        end
        result.phase        = phase_next;
        result.busy_res     = (phase_next != PH_ADDR);
        result.resp_addr    = addr_next;
        result.resp_func    = func_next;
        result.byte_count   = count_next;
        result.crc_calc     = crc_next;
        result.crc_received = crc_rx_next;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // parser state, updated as each beat is parsed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ADDR;
            addr_reg   <= 8'd0;
            func_reg   <= 8'd0;
            count_reg  <= 8'd0;
            index_reg  <= 8'd0;
            crc_reg    <= CRC_INIT;
            crc_rx_reg <= 16'd0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            addr_reg   <= addr_next;
            func_reg   <= func_next;
            count_reg  <= count_next;
            index_reg  <= index_next;
            crc_reg    <= crc_next;
            crc_rx_reg <= crc_rx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // busy flag tracks the reported phase
    a_busy_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.busy_res == (m_data.phase != PH_ADDR)))
        else $error("busy flag disagrees with phase");

    // a data byte leaves the parser in data or crc-high phase
    a_data_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.data_valid) |->
            (m_data.phase == PH_DATA || m_data.phase == PH_CRCHI))
        else $error("data byte reported outside data phase");

    // frame end always lands in the end phase
    a_end_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> (m_data.phase == PH_END))
        else $error("frame end without end phase");

    // both registers full under stall closes the input
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted with no room");

    // parser state only moves when a beat is parsed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(crc_reg) && $stable(phase_reg))
        else $error("parser state changed without a beat");

endmodule

### rtl/mrd_apb_regs.sv
// ----------------------------------------------------------------------------
// mrd_apb_regs
// APB register file holding the expected slave address.
// ----------------------------------------------------------------------------
module mrd_apb_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  expected_addr
);
    import mrd_pkg::*;

    logic [7:0] expected_addr_reg;
    logic [7:0] expected_addr_next;
    logic       wr_en;

    assign pready = 1'b1;

    // write decode
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        expected_addr_next = expected_addr_reg;
        if (wr_en && (paddr[2] == REG_EXPECTED_ADDR)) begin
            expected_addr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_addr_reg <= EXPECTED_ADDR_RESET;
        end else begin
            expected_addr_reg <= expected_addr_next;
        end
    end

    // read mux, word select only
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_EXPECTED_ADDR) begin
            prdata = {24'd0, expected_addr_reg};
        end
    end

    assign expected_addr = expected_addr_reg;

endmodule

### test/modbus_rtu_reply_deframer_core_tb.sv
// ----------------------------------------------------------------------------
// modbus_rtu_reply_deframer_core_tb
// Self-checking bench for the Modbus RTU reply deframer. It sends a short
// table of hand-picked bytes, then random reply frames under several slave
// addresses. Frames are mostly well formed, some are cut short or carry a
// wrong address, and junk bytes and releases are mixed in. Both channels
// idle at random. A bench-side parser predicts every result beat, and each
// result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module modbus_rtu_reply_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrd_pkg::*;

    localparam logic [15:0] MODBUS_POLY  = 16'hA001;
    localparam logic [15:0] MODBUS_SEED  = 16'hFFFF;
    localparam logic [2:0]  SLAVE_PADDR  = {REG_EXPECTED_ADDR, 2'b00};
    localparam int          N_DIRECTED   = 25;
    localparam int          N_PHASES     = 6;
    localparam int          PHASE_ITEMS  = 130;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          HOLD_AT_ITEM = 300;

    // pinned views that follow directly from reset
    localparam mrd_out_t NO_PIN    = '0;
    localparam mrd_out_t IDLE_VIEW = '{phase: PH_ADDR, crc_calc: 16'hFFFF, default: '0};
    localparam mrd_out_t ADDR_VIEW = '{phase: PH_FUNC, busy_res: 1'b1, resp_addr: 8'h01,
                                       crc_calc: 16'h807E, default: '0};

    typedef struct {
        logic       op;
        logic [7:0] rx;
        bit         pinned;
        mrd_out_t   want;
    } directed_row_t;

    // directed bytes, run with the reset slave address of one
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{OP_RELEASE, 8'h00, 1'b1, IDLE_VIEW},  // release straight after reset
        '{OP_BYTE,    8'h01, 1'b1, ADDR_VIEW},  // matching address
        '{OP_BYTE,    8'hFF, 1'b0, NO_PIN},     // function
        '{OP_BYTE,    8'h00, 1'b0, NO_PIN},     // zero count skips data
        '{OP_BYTE,    8'h00, 1'b0, NO_PIN},     // crc high
        '{OP_BYTE,    8'hFF, 1'b0, NO_PIN},     // crc low, frame end
        '{OP_BYTE,    8'hAA, 1'b0, NO_PIN},     // ignored after end
        '{OP_RELEASE, 8'hFF, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h01, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h00, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h03, 1'b0, NO_PIN},     // three data bytes
        '{OP_BYTE,    8'h00, 1'b0, NO_PIN},
        '{OP_BYTE,    8'hFF, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h5A, 1'b0, NO_PIN},
        '{OP_BYTE,    8'hFF, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h00, 1'b0, NO_PIN},
        '{OP_RELEASE, 8'h00, 1'b0, NO_PIN},
        '{OP_BYTE,    8'hFF, 1'b0, NO_PIN},     // wrong address ends the frame
        '{OP_BYTE,    8'h01, 1'b0, NO_PIN},     // ignored after end
        '{OP_RELEASE, 8'h00, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h01, 1'b0, NO_PIN},
        '{OP_BYTE,    8'h03, 1'b0, NO_PIN},
        '{OP_RELEASE, 8'h5A, 1'b0, NO_PIN},     // release in mid-frame
        '{OP_BYTE,    8'h00, 1'b0, NO_PIN},     // wrong address
        '{OP_RELEASE, 8'hA5, 1'b0, NO_PIN}
    };

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    mrd_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    mrd_out_t m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // bench copy of the parser state
    logic [7:0]  slave_addr;
    phase_t      cur_phase;
    logic [7:0]  cur_addr;
    logic [7:0]  cur_func;
    logic [7:0]  cur_count;
    logic [7:0]  next_index;
    logic [15:0] run_crc;
    logic [15:0] rx_crc;

    mrd_out_t replies_due [$];

    int  mismatches    = 0;
    int  items_counted = 0;
    int  beats_sent    = 0;
    int  results_seen  = 0;
    int  data_seen     = 0;
    int  frames_closed = 0;
    bit  sender_gaps   = 1'b1;
    bit  receiver_gaps = 1'b1;
    bit  hold_done     = 1'b0;

    modbus_rtu_reply_deframer_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // modbus crc over one byte, reflected, lsb first
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ MODBUS_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void clear_tracker();
        slave_addr = EXPECTED_ADDR_RESET;
        cur_phase  = PH_ADDR;
        cur_addr   = '0;
        cur_func   = '0;
        cur_count  = '0;
        next_index = '0;
        run_crc    = MODBUS_SEED;
        rx_crc     = '0;
    endfunction

    // advance the bench parser by one beat and build the reply it gives
    function automatic mrd_out_t parse_reply_beat(input logic op, input logic [7:0] b);
        mrd_out_t r;
        r = '0;
        if (op == OP_RELEASE) begin
            cur_phase = PH_ADDR;
        end else begin
            case (cur_phase)
                PH_ADDR: begin
                    next_index = '0;
                    run_crc    = modbus_crc_byte(MODBUS_SEED, b);
                    cur_addr   = b;
                    if (b != slave_addr) begin
                        cur_phase   = PH_END;
                        r.frame_end = 1'b1;
                    end else begin
                        cur_phase = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    run_crc   = modbus_crc_byte(run_crc, b);
                    cur_func  = b;
                    cur_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    run_crc   = modbus_crc_byte(run_crc, b);
                    cur_count = b;
                    cur_phase = (b == 8'h00) ? PH_CRCHI : PH_DATA;
                end
                PH_DATA: begin
                    run_crc      = modbus_crc_byte(run_crc, b);
                    r.data_valid = 1'b1;
                    r.data_byte  = b;
                    r.data_index = next_index;
                    next_index   = next_index + 8'd1;
                    if (next_index >= cur_count) cur_phase = PH_CRCHI;
                end
                PH_CRCHI: begin
                    rx_crc[15:8] = b;
                    cur_phase    = PH_CRCLO;
                end
                PH_CRCLO: begin
                    rx_crc[7:0] = b;
                    cur_phase   = PH_END;
                    r.frame_end = 1'b1;
                end
                default: begin
                    // end phase: byte ignored
                end
            endcase
        end
        r.phase        = cur_phase;
        r.busy_res     = (cur_phase != PH_ADDR);
        r.resp_addr    = cur_addr;
        r.resp_func    = cur_func;
        r.byte_count   = cur_count;
        r.crc_calc     = run_crc;
        r.crc_received = rx_crc;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    // offer one beat, hold it until accepted, then maybe idle a burst
    task automatic send_beat(input logic op, input logic [7:0] b,
                             input bit pinned = 1'b0, input mrd_out_t want = '0);
        mrd_out_t r;
        s_valid <= 1'b1;
        s_data  <= '{operation: op, rx_byte: b};
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (op == OP_RELEASE || cur_phase != PH_END) items_counted++;
        r = parse_reply_beat(op, b);
        if (r.data_valid) data_seen++;
        if (r.frame_end) frames_closed++;
        replies_due.push_back(pinned ? want : r);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // stop offering and let every expected result come back
    task automatic quiesce();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    // write the slave address, then read it back
    task automatic write_slave_addr(input logic [7:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLAVE_PADDR;
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        slave_addr = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[7:0] !== v) begin
            $error("expected_addr: expected %h, actual %h", v, prdata[7:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one reply frame: mostly well formed, sometimes cut short or misaddressed
    task automatic send_frame(input bit huge);
        logic [7:0] addr;
        logic [7:0] n;
        logic [7:0] b;
        int         total;
        int         stop_at;
        if ($urandom_range(0, 7) == 0) send_beat(OP_RELEASE, 8'($urandom));
        addr = (!huge && $urandom_range(0, 9) == 0) ? 8'($urandom) : slave_addr;
        if (huge)                           n = 8'hFF;
        else if ($urandom_range(0, 29) == 0) n = 8'($urandom_range(9, 64));
        else                                n = 8'($urandom_range(0, 6));
        total   = 5 + n;
        stop_at = total;
        if (addr != slave_addr)                       stop_at = 1;
        else if (!huge && $urandom_range(0, 9) == 0) stop_at = $urandom_range(1, total - 1);
        for (int k = 0; k < stop_at; k++) begin
            b = (k == 0) ? addr : (k == 2) ? n : 8'($urandom);
            send_beat(OP_BYTE, b);
        end
        // trailing noise, then release
        repeat ($urandom_range(0, 2)) send_beat(OP_BYTE, 8'($urandom));
        send_beat(OP_RELEASE, 8'($urandom));
    endtask

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && items_counted >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        mrd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                $error("result beat with nothing expected: %h", m_data);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                compare_field("phase",        16'(want.phase),        16'(m_data.phase));
                compare_field("busy_res",     16'(want.busy_res),     16'(m_data.busy_res));
                compare_field("resp_addr",    16'(want.resp_addr),    16'(m_data.resp_addr));
                compare_field("resp_func",    16'(want.resp_func),    16'(m_data.resp_func));
                compare_field("byte_count",   16'(want.byte_count),   16'(m_data.byte_count));
                compare_field("data_valid",   16'(want.data_valid),   16'(m_data.data_valid));
                compare_field("data_byte",    16'(want.data_byte),    16'(m_data.data_byte));
                compare_field("data_index",   16'(want.data_index),   16'(m_data.data_index));
                compare_field("crc_calc",     want.crc_calc,          m_data.crc_calc);
                compare_field("crc_received", want.crc_received,      m_data.crc_received);
                compare_field("frame_end",    16'(want.frame_end),    16'(m_data.frame_end));
            end
        end
    end

    // main sequence
    initial begin : stimulus
        logic [7:0] v;
        int         target;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        aresetn <= 1'b0;
        clear_tracker();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].op, directed_rows[i].rx,
                      directed_rows[i].pinned, directed_rows[i].want);
        end

        // random frames under several slave addresses, extremes first
        for (int p = 0; p < N_PHASES; p++) begin
            quiesce();
            if (p == 0)      v = 8'h00;
            else if (p == 1) v = 8'hFF;
            else             v = 8'($urandom);
            write_slave_addr(v);
            sender_gaps   = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            receiver_gaps = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (p == 0) send_frame(1'b1);
            target = N_DIRECTED + (p + 1) * PHASE_ITEMS;
            while (items_counted < target) send_frame(1'b0);
        end

        quiesce();
        repeat (8) @(posedge aclk);
        $display("ran %0d input beats (%0d parsed), %0d result beats checked",
                 beats_sent, items_counted, results_seen);
        $display("streamed %0d data bytes, closed %0d frames, %0d slave address settings",
                 data_seen, frames_closed, N_PHASES + 1);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #4_000_000;
        $display("timeout waiting for the deframer");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
rtl/mrd_pkg.sv
rtl/mrd_apb_regs.sv
rtl/modbus_rtu_reply_deframer_core.sv
test/modbus_rtu_reply_deframer_core_tb.sv
